>>> sv/hcbp_pkg.sv
`default_nettype none
package hcbp_pkg;

	localparam int BYTE_W = 8;
	localparam int CMD_W = 2;
	localparam int SYM_W = 8;
	localparam int VAL_W = 32;
	localparam int LEN_W = 6;
	localparam int PAD_W = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

endpackage
`default_nettype wire

>>> sv/huffman_code_bit_packer_unit.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: command; tdata: symbol, code_value, length
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_byte; tlast: last
// cfg       in   cfg_valid/cfg_ready           cfg_data: pad_bits
//
// Front takes one request per cycle if the queue has room; load and unknown requests finish there.
// Encode: the back merges the code into the bit buffer, then sends out each whole byte
// (0 to (7+MAX_CODE_LEN)/8 bytes). Flush: emits any partial byte. The back packer sets the rate.
// A 4-entry queue between the table lookup and the packer lets either side stall.
// Reset clears the bit buffer and the stream state; the code table is not cleared.
`default_nettype none
module huffman_code_bit_packer_unit import hcbp_pkg::*; #(
	parameter int SYMBOLS = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [47:0]         s_axis_tdata,  // symbol[7:0], code_value[39:8], code_length[45:40]
	input  wire logic [CMD_W-1:0]    s_axis_tuser,  // command[1:0]
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [BYTE_W-1:0]        m_axis_tdata,  // out_byte[7:0]
	output logic                     m_axis_tlast,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [PAD_W-1:0]    cfg_data
);

	localparam int LW = $clog2(MAX_CODE_LEN+1);
	localparam int OP_W = 1 + LW + MAX_CODE_LEN;
	localparam int FILL_W = $clog2(QUEUE_DEPTH+1);

	logic [PAD_W-1:0]  pad_q;
	logic              push;
	logic [OP_W-1:0]   push_data;
	logic              pop;
	logic              rd_valid;
	logic [OP_W-1:0]   rd_data;
	logic [FILL_W-1:0] fill;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= '0;
		end else if (cfg_valid) begin
			pad_q <= cfg_data;
		end
	end

	hcbp_front #(
		.SYMBOLS(SYMBOLS),
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.LW(LW),
		.OP_W(OP_W),
		.FILL_W(FILL_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd(cmd_t'(s_axis_tuser)),
		.in_symbol(s_axis_tdata[7:0]),
		.in_value(s_axis_tdata[39:8]),
		.in_length(s_axis_tdata[45:40]),
		.queue_fill(fill),
		.push(push),
		.push_data(push_data)
	);

	hcbp_queue #(
		.DATA_W(OP_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.rd_valid(rd_valid),
		.rd_data(rd_data),
		.fill(fill)
	);

	hcbp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.LW(LW),
		.OP_W(OP_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pad(pad_q),
		.op_valid(rd_valid),
		.op_data(rd_data),
		.op_pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

endmodule
`default_nettype wire

>>> sv/hcbp_queue.sv
`default_nettype none
module hcbp_queue import hcbp_pkg::*; #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [DATA_W-1:0]            push_data,
	input  wire logic                         pop,
	output logic                              rd_valid,
	output logic [DATA_W-1:0]                 rd_data,
	output logic [$clog2(DEPTH+1)-1:0]        fill
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign rd_valid = count_q != '0;
	assign rd_data = slot_q[rd_ptr_q];
	assign fill = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/hcbp_front.sv
`default_nettype none
module hcbp_front import hcbp_pkg::*; #(
	parameter int SYMBOLS = 256,
	parameter int MAX_CODE_LEN = 32,
	parameter int LW = $clog2(MAX_CODE_LEN+1),
	parameter int OP_W = 1 + LW + MAX_CODE_LEN,
	parameter int FILL_W = $clog2(QUEUE_DEPTH+1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cmd_t              in_cmd,
	input  wire logic [SYM_W-1:0]  in_symbol,
	input  wire logic [VAL_W-1:0]  in_value,
	input  wire logic [LEN_W-1:0]  in_length,
	input  wire logic [FILL_W-1:0] queue_fill,
	output logic                   push,
	output logic [OP_W-1:0]        push_data
);

	localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int MAX = MAX_CODE_LEN;

	logic [LW+VAL_W-1:0] table_mem [SYMBOLS];
	logic [LW+VAL_W-1:0] entry_s1;
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic                in_range_s1;

	logic                accept;
	logic                in_range;
	logic [LW-1:0]       len_sat;
	logic [AW-1:0]       idx;
	logic [LW-1:0]       rd_len;
	logic [MAX-1:0]      rd_value;
	logic [LEN_W-1:0]    shamt;
	logic [MAX-1:0]      code_left;

	assign in_ready = ({1'b0, queue_fill} + (FILL_W+1)'(valid_s1)) < (FILL_W+1)'(QUEUE_DEPTH);
	assign accept = in_valid && in_ready;
	assign in_range = {1'b0, in_symbol} < (SYM_W+1)'(SYMBOLS);
	assign idx = in_symbol[AW-1:0];
	assign len_sat = (in_length > LEN_W'(MAX)) ? LW'(MAX) : LW'(in_length);

	always_ff @(posedge clk) begin
		if (accept && in_cmd == CMD_LOAD && in_range) begin
			table_mem[idx] <= {len_sat, in_value};
		end
		if (accept) begin
			entry_s1 <= table_mem[idx];
			cmd_s1 <= in_cmd;
			in_range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// left-align the code in MAX bits; bits above the length fall off the top
	always_comb begin
		rd_len = in_range_s1 ? entry_s1[LW+VAL_W-1 -: LW] : '0;
		rd_value = MAX'(entry_s1[VAL_W-1:0]);
		shamt = LEN_W'(MAX) - LEN_W'(rd_len);
		code_left = (rd_len == '0) ? '0 : (rd_value << shamt);
		push = valid_s1 && (cmd_s1 == CMD_ENCODE || cmd_s1 == CMD_FLUSH);
		push_data = {cmd_s1 == CMD_FLUSH, rd_len, code_left};
	end

endmodule
`default_nettype wire

>>> sv/hcbp_back.sv
`default_nettype none
module hcbp_back import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = 32,
	parameter int LW = $clog2(MAX_CODE_LEN+1),
	parameter int OP_W = 1 + LW + MAX_CODE_LEN
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [PAD_W-1:0]  pad,
	input  wire logic              op_valid,
	input  wire logic [OP_W-1:0]   op_data,
	output logic                   op_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   out_last
);

	localparam int MAX = MAX_CODE_LEN;
	localparam int W = MAX + 7;
	localparam int CW = $clog2(MAX + 8);

	// bit buffer kept MSB-aligned; bits past cnt_q are always zero
	logic [W-1:0]      acc_q;
	logic [CW-1:0]     cnt_q;
	logic              open_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              op_flush;
	logic [LW-1:0]     op_len;
	logic [MAX-1:0]    op_code;
	logic              out_ok;
	logic [2:0]        base_cnt;
	logic [W-1:0]      base_acc;
	logic [W-1:0]      merged;
	logic              has_byte;
	logic              emit;
	logic [BYTE_W-1:0] byte_d;
	logic              last_d;
	logic [W-1:0]      acc_d;
	logic [CW-1:0]     cnt_d;
	logic              open_d;

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	always_comb begin
		op_flush = op_data[OP_W-1];
		op_len = op_data[MAX+LW-1 -: LW];
		op_code = op_data[MAX-1:0];
		out_ok = !out_valid_q || out_ready;
		base_cnt = open_q ? cnt_q[2:0] : pad;
		base_acc = open_q ? acc_q : '0;
		merged = base_acc | ({op_code, 7'b0} >> base_cnt);
		has_byte = cnt_q >= CW'(BYTE_W);
		op_pop = op_valid && !has_byte && (!op_flush || out_ok);

		emit = 1'b0;
		byte_d = acc_q[W-1 -: BYTE_W];
		last_d = 1'b0;
		acc_d = acc_q;
		cnt_d = cnt_q;
		open_d = open_q;

		if (has_byte) begin
			if (out_ok) begin
				emit = 1'b1;
				last_d = (cnt_q - CW'(BYTE_W)) < CW'(BYTE_W);
				acc_d = acc_q << BYTE_W;
				cnt_d = cnt_q - CW'(BYTE_W);
			end
		end else if (op_pop) begin
			if (op_flush) begin
				// partial byte goes out right-aligned
				emit = open_q && cnt_q != '0;
				byte_d = acc_q[W-1 -: BYTE_W] >> (4'd8 - {1'b0, cnt_q[2:0]});
				last_d = 1'b1;
				acc_d = '0;
				cnt_d = '0;
				open_d = 1'b0;
			end else begin
				acc_d = merged;
				cnt_d = CW'(base_cnt) + CW'(op_len);
				open_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			open_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			open_q <= open_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
		end
	end

endmodule
`default_nettype wire
